[src/pce_pkg.sv]
`timescale 1ns / 1ps

package pce_pkg;

  // Request command codes
  typedef enum logic [3:0] {
    CMD_CTRL       = 4'd0,
    CMD_SWEEP      = 4'd1,
    CMD_TIMER_LO   = 4'd2,
    CMD_TIMER_HI   = 4'd3,
    CMD_ENABLE     = 4'd4,
    CMD_TICK       = 4'd5,
    CMD_QUARTER    = 4'd6,
    CMD_HALF       = 4'd7,
    CMD_LEN_SWEEP  = 4'd8
  } cmd_t;

  localparam logic [15:0] PERIOD_MAX = 16'h07FF;
  localparam logic [15:0] PERIOD_MIN = 16'd8;
  localparam logic [3:0]  ENV_TOP    = 4'd15;

  // Duty patterns, bit k is sequencer step k
  localparam logic [7:0] DUTY_TAB [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

  // Length counter load values
  function automatic logic [7:0] len_lookup(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:  v = 8'd10;   5'd1:  v = 8'd254;  5'd2:  v = 8'd20;  5'd3:  v = 8'd2;
      5'd4:  v = 8'd40;   5'd5:  v = 8'd4;    5'd6:  v = 8'd80;  5'd7:  v = 8'd6;
      5'd8:  v = 8'd160;  5'd9:  v = 8'd8;    5'd10: v = 8'd60;  5'd11: v = 8'd10;
      5'd12: v = 8'd14;   5'd13: v = 8'd12;   5'd14: v = 8'd26;  5'd15: v = 8'd14;
      5'd16: v = 8'd12;   5'd17: v = 8'd16;   5'd18: v = 8'd24;  5'd19: v = 8'd18;
      5'd20: v = 8'd48;   5'd21: v = 8'd20;   5'd22: v = 8'd96;  5'd23: v = 8'd22;
      5'd24: v = 8'd192;  5'd25: v = 8'd24;   5'd26: v = 8'd72;  5'd27: v = 8'd26;
      5'd28: v = 8'd16;   5'd29: v = 8'd28;   5'd30: v = 8'd32;  5'd31: v = 8'd30;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

[src/pulse_channel_envelope_sweep.sv]
`timescale 1ns / 1ps

// Square-wave sound channel: period timer, duty sequencer, envelope,
// length counter and sweep unit.
//
// Input channel (in_valid/in_ready, in_cmd, in_data): one request per
// command - register write, enable write, timer tick or frame clock.
// Result channel (out_valid/out_ready, out_level, out_length_active):
// exactly one result per request, in order, showing the channel after it.
// Configuration: cfg_we with cfg_wdata sets the extra-one-on-negate flag;
// write it only while no request is in flight.
//
// A request is registered at acceptance, then applied to the channel
// state when the result stage advances, raising out_valid. Throughput
// is one request per cycle when results flow (single state update stage).
// The level is decoded from the state registers, which hold while a
// result waits, so a stalled receiver keeps out_level stable. A request
// may still be taken into the input register during such a stall.
//
// Reset (rst_n low, synchronous) empties both stages and returns all
// channel state to its power-on values (halt/loop flag set, rest zero).

module pulse_channel_envelope_sweep (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_cmd,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_level,
  output logic       out_length_active,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  // Handshake control
  logic       req_v_r;
  logic [3:0] req_cmd_r;
  logic [7:0] req_data_r;
  logic       out_v_r;
  logic       adv;
  logic       apply;

  assign adv      = !out_v_r || out_ready;
  assign apply    = req_v_r && adv;
  assign in_ready = !req_v_r || adv;
  assign out_valid = out_v_r;

  // Channel state
  logic        neg_one_r;
  logic        chan_on_r,     chan_on_nxt;
  logic [15:0] period_r,      period_nxt;
  logic [15:0] countdown_r,   countdown_nxt;
  logic [1:0]  duty_sel_r,    duty_sel_nxt;
  logic [2:0]  duty_step_r,   duty_step_nxt;
  logic [7:0]  len_cnt_r,     len_cnt_nxt;
  logic        halt_r,        halt_nxt;
  logic        env_rst_r,     env_rst_nxt;
  logic [3:0]  env_div_r,     env_div_nxt;
  logic [3:0]  env_lvl_r,     env_lvl_nxt;
  logic [3:0]  env_set_r,     env_set_nxt;
  logic        fixed_vol_r,   fixed_vol_nxt;
  logic        swp_on_r,      swp_on_nxt;
  logic [2:0]  swp_int_r,     swp_int_nxt;
  logic        swp_down_r,    swp_down_nxt;
  logic [2:0]  swp_amt_r,     swp_amt_nxt;
  logic        swp_rst_r,     swp_rst_nxt;
  logic [2:0]  swp_div_r,     swp_div_nxt;

  logic        do_env;
  logic        do_len_swp;
  logic [15:0] swp_delta;
  pce_pkg::cmd_t cmd;

  assign cmd       = pce_pkg::cmd_t'(req_cmd_r);
  assign swp_delta = period_r >> swp_amt_r;

  // Request decode and next channel state
  always_comb begin
    chan_on_nxt   = chan_on_r;
    period_nxt    = period_r;
    countdown_nxt = countdown_r;
    duty_sel_nxt  = duty_sel_r;
    duty_step_nxt = duty_step_r;
    len_cnt_nxt   = len_cnt_r;
    halt_nxt      = halt_r;
    env_rst_nxt   = env_rst_r;
    env_div_nxt   = env_div_r;
    env_lvl_nxt   = env_lvl_r;
    env_set_nxt   = env_set_r;
    fixed_vol_nxt = fixed_vol_r;
    swp_on_nxt    = swp_on_r;
    swp_int_nxt   = swp_int_r;
    swp_down_nxt  = swp_down_r;
    swp_amt_nxt   = swp_amt_r;
    swp_rst_nxt   = swp_rst_r;
    swp_div_nxt   = swp_div_r;
    do_env        = 1'b0;
    do_len_swp    = 1'b0;

    case (cmd)
      pce_pkg::CMD_CTRL: begin
        duty_sel_nxt  = req_data_r[7:6];
        halt_nxt      = req_data_r[5];
        fixed_vol_nxt = req_data_r[4];
        env_set_nxt   = req_data_r[3:0];
        env_rst_nxt   = 1'b1;
      end
      pce_pkg::CMD_SWEEP: begin
        swp_on_nxt   = req_data_r[7];
        swp_int_nxt  = req_data_r[6:4];
        swp_down_nxt = req_data_r[3];
        swp_amt_nxt  = req_data_r[2:0];
        swp_rst_nxt  = 1'b1;
      end
      pce_pkg::CMD_TIMER_LO: begin
        period_nxt = {period_r[15:8], req_data_r};
      end
      pce_pkg::CMD_TIMER_HI: begin
        if (chan_on_r) begin
          len_cnt_nxt = pce_pkg::len_lookup(req_data_r[7:3]);
        end
        period_nxt    = {5'd0, req_data_r[2:0], period_r[7:0]};
        env_rst_nxt   = 1'b1;
        duty_step_nxt = 3'd0;
      end
      pce_pkg::CMD_ENABLE: begin
        chan_on_nxt = req_data_r[0];
        if (!req_data_r[0]) begin
          len_cnt_nxt = 8'd0;
        end
      end
      pce_pkg::CMD_TICK: begin
        if (countdown_r == 16'd0) begin
          countdown_nxt = period_r;
          duty_step_nxt = duty_step_r + 3'd1;
        end else begin
          countdown_nxt = countdown_r - 16'd1;
        end
      end
      pce_pkg::CMD_QUARTER: begin
        do_env = 1'b1;
      end
      pce_pkg::CMD_HALF: begin
        do_env     = 1'b1;
        do_len_swp = 1'b1;
      end
      pce_pkg::CMD_LEN_SWEEP: begin
        do_len_swp = 1'b1;
      end
      default: begin
      end
    endcase

    // Envelope clock
    if (do_env) begin
      if (env_rst_r) begin
        env_lvl_nxt = pce_pkg::ENV_TOP;
        env_div_nxt = env_set_r;
        env_rst_nxt = 1'b0;
      end else if (env_div_r != 4'd0) begin
        env_div_nxt = env_div_r - 4'd1;
      end else begin
        env_div_nxt = env_set_r;
        if (env_lvl_r != 4'd0) begin
          env_lvl_nxt = env_lvl_r - 4'd1;
        end else if (halt_r) begin
          env_lvl_nxt = pce_pkg::ENV_TOP;
        end
      end
    end

    // Length and sweep clock
    if (do_len_swp) begin
      if (!halt_r && len_cnt_r != 8'd0) begin
        len_cnt_nxt = len_cnt_r - 8'd1;
      end
      if (swp_div_r == 3'd0 && swp_on_r) begin
        if (swp_down_r) begin
          period_nxt = period_r - (swp_delta + {15'd0, neg_one_r});
        end else begin
          period_nxt = period_r + swp_delta;
        end
      end
      if (swp_div_r == 3'd0 || swp_rst_r) begin
        swp_div_nxt = swp_int_r;
        swp_rst_nxt = 1'b0;
      end else begin
        swp_div_nxt = swp_div_r - 3'd1;
      end
    end
  end

  // Pipeline and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r     <= 1'b0;
      out_v_r     <= 1'b0;
      neg_one_r   <= 1'b0;
      chan_on_r   <= 1'b0;
      period_r    <= 16'd0;
      countdown_r <= 16'd0;
      duty_sel_r  <= 2'd0;
      duty_step_r <= 3'd0;
      len_cnt_r   <= 8'd0;
      halt_r      <= 1'b1;
      env_rst_r   <= 1'b0;
      env_div_r   <= 4'd0;
      env_lvl_r   <= 4'd0;
      env_set_r   <= 4'd0;
      fixed_vol_r <= 1'b0;
      swp_on_r    <= 1'b0;
      swp_int_r   <= 3'd0;
      swp_down_r  <= 1'b0;
      swp_amt_r   <= 3'd0;
      swp_rst_r   <= 1'b0;
      swp_div_r   <= 3'd0;
    end else begin
      if (cfg_we) begin
        neg_one_r <= cfg_wdata;
      end
      if (in_ready) begin
        req_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= req_v_r;
      end
      if (apply) begin
        chan_on_r   <= chan_on_nxt;
        period_r    <= period_nxt;
        countdown_r <= countdown_nxt;
        duty_sel_r  <= duty_sel_nxt;
        duty_step_r <= duty_step_nxt;
        len_cnt_r   <= len_cnt_nxt;
        halt_r      <= halt_nxt;
        env_rst_r   <= env_rst_nxt;
        env_div_r   <= env_div_nxt;
        env_lvl_r   <= env_lvl_nxt;
        env_set_r   <= env_set_nxt;
        fixed_vol_r <= fixed_vol_nxt;
        swp_on_r    <= swp_on_nxt;
        swp_int_r   <= swp_int_nxt;
        swp_down_r  <= swp_down_nxt;
        swp_amt_r   <= swp_amt_nxt;
        swp_rst_r   <= swp_rst_nxt;
        swp_div_r   <= swp_div_nxt;
      end
    end
  end

  // Request payload capture
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_cmd_r  <= in_cmd;
      req_data_r <= in_data;
    end
  end

  // Output level decode from the state registers
  logic [16:0] swp_target;
  logic [7:0]  duty_pat;
  logic        mute;

  assign swp_target = {1'b0, period_r} + {1'b0, swp_delta};
  assign duty_pat   = pce_pkg::DUTY_TAB[duty_sel_r];

  always_comb begin
    mute = !chan_on_r || (len_cnt_r == 8'd0) || !duty_pat[duty_step_r]
        || (period_r < pce_pkg::PERIOD_MIN) || (period_r > pce_pkg::PERIOD_MAX)
        || (!swp_down_r && (swp_target > {1'b0, pce_pkg::PERIOD_MAX}));
    if (mute) begin
      out_level = 4'd0;
    end else if (fixed_vol_r) begin
      out_level = env_set_r;
    end else begin
      out_level = env_lvl_r;
    end
  end

  assign out_length_active = (len_cnt_r != 8'd0);

  // Checks
  a_len_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (len_cnt_r != 8'd0) |-> chan_on_r)
    else $error("length counter loaded while channel disabled");

  a_level_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_level != 4'd0) |-> out_length_active)
    else $error("nonzero level with length counter at zero");

  a_state_holds_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |=> ($stable(period_r) && $stable(len_cnt_r)
      && $stable(env_lvl_r)))
    else $error("channel state changed while result stalled");

  a_req_kept_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (req_v_r && !adv) |=> req_v_r)
    else $error("pending request dropped during stall");

endmodule

[test/pulse_channel_envelope_sweep_tb.sv]
`timescale 1ns / 1ps

module pulse_channel_envelope_sweep_tb;

  // Command codes the block does not decode
  localparam logic [3:0] CMD_SPARE_FIRST = 4'd9;
  localparam logic [3:0] CMD_SPARE_LAST  = 4'd15;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_REQS    = 160;
  localparam int HOLD_CYCLES   = 300;
  localparam int DIR_ROWS      = 24;

  // Idle percentages per phase flavour: none, sender, receiver, both
  localparam int SEND_IDLE [4] = '{0, 52, 0, 6};
  localparam int RECV_IDLE [4] = '{0, 0, 52, 6};

  localparam logic [7:0] LEN_LOAD [32] = '{
    8'd10, 8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,  8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12, 8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  // Bit k of a pattern is the output of sequencer step k
  localparam logic [7:0] DUTY_WAVE [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

  typedef struct packed {
    logic [3:0] level;
    logic       active;
  } chan_out_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] data;
    logic       typed;
    logic [3:0] level;
    logic       active;
  } dir_row_t;

  // Directed requests; typed rows carry an expectation that is obvious
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{CMD_SPARE_FIRST,         8'h00, 1'b1, 4'd0, 1'b0},  // undecoded, nothing moves
    '{CMD_SPARE_LAST,          8'hFF, 1'b1, 4'd0, 1'b0},
    '{pce_pkg::CMD_TIMER_HI,   8'hFF, 1'b1, 4'd0, 1'b0},  // disabled: no length load
    '{pce_pkg::CMD_ENABLE,     8'hFE, 1'b1, 4'd0, 1'b0},  // only bit 0 counts
    '{pce_pkg::CMD_ENABLE,     8'h01, 1'b1, 4'd0, 1'b0},
    '{pce_pkg::CMD_CTRL,       8'hFF, 1'b1, 4'd0, 1'b0},  // length still zero
    '{pce_pkg::CMD_TIMER_LO,   8'hFF, 1'b0, 4'd0, 1'b0},
    '{pce_pkg::CMD_TIMER_HI,   8'h00, 1'b0, 4'd0, 1'b0},
    '{pce_pkg::CMD_SWEEP,      8'h00, 1'b0, 4'd0, 1'b0},
    '{pce_pkg::CMD_TICK,       8'h00, 1'b0, 4'd0, 1'b0},
    '{pce_pkg::CMD_TICK,       8'hFF, 1'b0, 4'd0, 1'b0},
    '{pce_pkg::CMD_QUARTER,    8'h00, 1'b0, 4'd0, 1'b0},
    '{pce_pkg::CMD_HALF,       8'hFF, 1'b0, 4'd0, 1'b0},
    '{pce_pkg::CMD_LEN_SWEEP,  8'h00, 1'b0, 4'd0, 1'b0},
    '{pce_pkg::CMD_CTRL,       8'h30, 1'b0, 4'd0, 1'b0},
    '{pce_pkg::CMD_TIMER_HI,   8'h08, 1'b0, 4'd0, 1'b0},  // longest length load
    '{pce_pkg::CMD_SWEEP,      8'h88, 1'b0, 4'd0, 1'b0},  // down, zero shift
    '{pce_pkg::CMD_LEN_SWEEP,  8'hFF, 1'b0, 4'd0, 1'b0},  // period wipes to zero
    '{pce_pkg::CMD_TIMER_LO,   8'h00, 1'b0, 4'd0, 1'b0},
    '{pce_pkg::CMD_TIMER_HI,   8'hFF, 1'b0, 4'd0, 1'b0},
    '{pce_pkg::CMD_SWEEP,      8'hF0, 1'b0, 4'd0, 1'b0},  // up, target overflows
    '{pce_pkg::CMD_HALF,       8'h00, 1'b0, 4'd0, 1'b0},
    '{pce_pkg::CMD_CTRL,       8'h0F, 1'b0, 4'd0, 1'b0},  // decaying envelope
    '{pce_pkg::CMD_ENABLE,     8'h00, 1'b1, 4'd0, 1'b0}   // disable clears length
  };

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [3:0] in_cmd    = '0;
  logic [7:0] in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_level;
  logic       out_length_active;
  logic       cfg_we    = 1'b0;
  logic       cfg_wdata = 1'b0;

  // Channel copy used for prediction
  logic        neg_plus_one;
  logic        tone_on;
  logic [15:0] tone_period;
  logic [15:0] tone_count;
  logic [1:0]  duty_sel;
  logic [2:0]  seq_pos;
  logic [7:0]  len_ctr;
  logic        len_halt;
  logic        env_start;
  logic [3:0]  env_div;
  logic [3:0]  env_vol;
  logic [3:0]  env_param;
  logic        const_vol;
  logic        sw_en;
  logic [2:0]  sw_rate;
  logic        sw_neg;
  logic [2:0]  sw_shift;
  logic        sw_reload;
  logic [2:0]  sw_div;

  chan_out_t expected_out [$];
  int        mismatches    = 0;
  int        results_seen  = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_left     = 0;

  pulse_channel_envelope_sweep dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_level         (out_level),
    .out_length_active (out_length_active),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Envelope divider and decay, shared by quarter and half frames
  task automatic envelope_clock();
    if (env_start) begin
      env_vol   = pce_pkg::ENV_TOP;
      env_div   = env_param;
      env_start = 1'b0;
    end else if (env_div != 0) begin
      env_div = env_div - 4'd1;
    end else begin
      env_div = env_param;
      if (env_vol != 0)
        env_vol = env_vol - 4'd1;
      else if (len_halt)
        env_vol = pce_pkg::ENV_TOP;
    end
  endtask

  // Length countdown and sweep divider; period wraps at 16 bits
  task automatic length_sweep_clock();
    logic [15:0] step;
    if (!len_halt && len_ctr != 0)
      len_ctr = len_ctr - 8'd1;
    if (sw_div == 0 && sw_en) begin
      step = tone_period >> sw_shift;
      if (sw_neg)
        tone_period = tone_period - (step + {15'd0, neg_plus_one});
      else
        tone_period = tone_period + step;
    end
    if (sw_div == 0 || sw_reload) begin
      sw_div    = sw_rate;
      sw_reload = 1'b0;
    end else begin
      sw_div = sw_div - 3'd1;
    end
  endtask

  // Apply one request to the channel copy and derive the level it shows
  task automatic predict_request(input logic [3:0] cmd, input logic [7:0] d,
                                 output chan_out_t res);
    logic [16:0] target;
    case (cmd)
      pce_pkg::CMD_CTRL: begin
        duty_sel  = d[7:6];
        len_halt  = d[5];
        const_vol = d[4];
        env_param = d[3:0];
        env_start = 1'b1;
      end
      pce_pkg::CMD_SWEEP: begin
        sw_en     = d[7];
        sw_rate   = d[6:4];
        sw_neg    = d[3];
        sw_shift  = d[2:0];
        sw_reload = 1'b1;
      end
      pce_pkg::CMD_TIMER_LO: tone_period[7:0] = d;
      pce_pkg::CMD_TIMER_HI: begin
        if (tone_on)
          len_ctr = LEN_LOAD[d[7:3]];
        tone_period = {5'd0, d[2:0], tone_period[7:0]};
        env_start   = 1'b1;
        seq_pos     = 3'd0;
      end
      pce_pkg::CMD_ENABLE: begin
        tone_on = d[0];
        if (!d[0])
          len_ctr = 8'd0;
      end
      pce_pkg::CMD_TICK: begin
        if (tone_count == 0) begin
          tone_count = tone_period;
          seq_pos    = seq_pos + 3'd1;
        end else begin
          tone_count = tone_count - 16'd1;
        end
      end
      pce_pkg::CMD_QUARTER: envelope_clock();
      pce_pkg::CMD_HALF: begin
        envelope_clock();
        length_sweep_clock();
      end
      pce_pkg::CMD_LEN_SWEEP: length_sweep_clock();
      default: ;
    endcase

    target = {1'b0, tone_period} + {1'b0, tone_period >> sw_shift};
    if (!tone_on || len_ctr == 0 || !DUTY_WAVE[duty_sel][seq_pos] ||
        tone_period < pce_pkg::PERIOD_MIN || tone_period > pce_pkg::PERIOD_MAX ||
        (!sw_neg && target > {1'b0, pce_pkg::PERIOD_MAX}))
      res.level = 4'd0;
    else
      res.level = const_vol ? env_param : env_vol;
    res.active = (len_ctr != 0);
  endtask

  // Offer one request, wait for acceptance, then queue what it should give
  task automatic issue(input logic [3:0] cmd, input logic [7:0] d,
                       input logic typed, input chan_out_t given);
    chan_out_t calc;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    predict_request(cmd, d, calc);
    expected_out.push_back(typed ? given : calc);
  endtask

  // Register write once the pipeline has drained
  task automatic set_cfg(input logic v);
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    neg_plus_one = v;
  endtask

  // Result checker and receiver back-pressure
  always @(posedge clk) begin
    chan_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        if (mismatches < 10)
          $display("result %0d with no request pending: level %0d active %0b",
                   results_seen, out_level, out_length_active);
        mismatches++;
      end else begin
        want = expected_out.pop_front();
        if (out_level !== want.level || out_length_active !== want.active) begin
          if (mismatches < 10)
            $display("result %0d: expected level %0d active %0b, got level %0d active %0b",
                     results_seen, want.level, want.active, out_level, out_length_active);
          mismatches++;
        end
      end
      results_seen++;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int         r;
    logic [3:0] c;
    logic [7:0] d;

    neg_plus_one = 1'b0;
    tone_on      = 1'b0;
    tone_period  = '0;
    tone_count   = '0;
    duty_sel     = '0;
    seq_pos      = '0;
    len_ctr      = '0;
    len_halt     = 1'b1;
    env_start    = 1'b0;
    env_div      = '0;
    env_vol      = '0;
    env_param    = '0;
    const_vol    = 1'b0;
    sw_en        = 1'b0;
    sw_rate      = '0;
    sw_neg       = 1'b0;
    sw_shift     = '0;
    sw_reload    = 1'b0;
    sw_div       = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    set_cfg(1'b0);
    for (int i = 0; i < DIR_ROWS; i++)
      issue(DIR_TABLE[i].cmd, DIR_TABLE[i].data, DIR_TABLE[i].typed,
            {DIR_TABLE[i].level, DIR_TABLE[i].active});

    // Random phases, flipping the negate flag and the idle pattern
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_cfg(ph[0] ? 1'b0 : 1'b1);
      send_idle_pct = SEND_IDLE[ph % 4];
      recv_idle_pct = RECV_IDLE[ph % 4];
      // long receiver hold while requests keep coming
      if (ph == 4)
        hold_left = HOLD_CYCLES;

      // bring the channel up with random settings
      issue(pce_pkg::CMD_ENABLE, {7'($urandom), 1'b1}, 1'b0, '0);
      issue(pce_pkg::CMD_CTRL, 8'($urandom), 1'b0, '0);
      issue(pce_pkg::CMD_SWEEP, 8'($urandom), 1'b0, '0);
      issue(pce_pkg::CMD_TIMER_LO, 8'($urandom_range(8, 24)), 1'b0, '0);
      issue(pce_pkg::CMD_TIMER_HI, {5'($urandom), 3'd0}, 1'b0, '0);

      for (int n = 0; n < PHASE_REQS; n++) begin
        r = $urandom_range(0, 99);
        d = 8'($urandom);
        if (r < 40) begin
          c = pce_pkg::CMD_TICK;
        end else if (r < 48) begin
          c = pce_pkg::CMD_QUARTER;
        end else if (r < 56) begin
          c = pce_pkg::CMD_HALF;
        end else if (r < 62) begin
          c = pce_pkg::CMD_LEN_SWEEP;
        end else if (r < 68) begin
          c = pce_pkg::CMD_CTRL;
        end else if (r < 73) begin
          c = pce_pkg::CMD_SWEEP;
        end else if (r < 80) begin
          c = pce_pkg::CMD_TIMER_LO;
          if ($urandom_range(0, 9) < 7)
            d = 8'($urandom_range(8, 24));
        end else if (r < 87) begin
          // keep periods short most of the time so the sequencer moves
          c = pce_pkg::CMD_TIMER_HI;
          if ($urandom_range(0, 39) != 0)
            d[2:0] = 3'd0;
        end else if (r < 93) begin
          c = pce_pkg::CMD_ENABLE;
          if ($urandom_range(0, 9) != 0)
            d[0] = 1'b1;
        end else if (r < 97) begin
          c = 4'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        end else begin
          c = 4'($urandom);
        end
        issue(c, d, 1'b0, '0);
      end
    end

    // Drain and report
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_out.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[files.f]
src/pce_pkg.sv
src/pulse_channel_envelope_sweep.sv
test/pulse_channel_envelope_sweep_tb.sv
